[src/bbl_pkg.sv]
// Shared types, sizes and codes of the byte-budget LRU cache.
`timescale 1ns / 1ps
`default_nettype none
package bbl_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int SLOT_W   = 4;
   localparam int KEY_W    = 32;
   localparam int LEN_W    = 19;
   localparam int SIZE_W   = 20;
   localparam int WORD_W   = 32;
   localparam int BUDGET_W = 27;
   localparam int STAT_W   = 3;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 27'd4194304;

   localparam logic [STAT_W-1:0] ST_EVICTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_HIT     = 3'd1;
   localparam logic [STAT_W-1:0] ST_MISS    = 3'd2;
   localparam logic [STAT_W-1:0] ST_STORED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_TOO_BIG = 3'd4;
   localparam logic [STAT_W-1:0] ST_PRESENT = 3'd5;

   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_PROMOTE = 2'd1;
   localparam logic [1:0] OP_EVICT   = 2'd2;
   localparam logic [1:0] OP_STORE   = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  promote_rank;
      logic [IDX_W-1:0]  oldest_rank;
      logic [KEY_W-1:0]  key;
      logic [LEN_W-1:0]  head_len;
      logic [LEN_W-1:0]  suffix_len;
      logic [WORD_W-1:0] suffix_start;
      logic [WORD_W-1:0] file_size;
   } cell_ctl_type;

   typedef struct packed {
      logic              valid;
      logic              match;
      logic              is_oldest;
      logic              first_free;
      logic [IDX_W-1:0]  rank;
      logic [KEY_W-1:0]  key;
      logic [LEN_W-1:0]  head_len;
      logic [LEN_W-1:0]  suffix_len;
      logic [WORD_W-1:0] suffix_start;
      logic [WORD_W-1:0] file_size;
   } cell_stat_type;

endpackage
`default_nettype wire

[src/byte_budget_lru_cache_core.sv]
// Top level of the byte-budget LRU cache: command sequencer, byte count and result register.
//
// The cache holds up to ENTRIES file-head entries in a row of slot cells,
// tracking least-recently-used order and a running byte total against the
// csr_write_data budget. A lookup transaction produces one result (hit with
// metadata, or miss). An insert transaction produces one result when refused
// (too big, already present), otherwise zero or more evictions, oldest first,
// followed by the stored result; rsp_last marks the final result of each
// transaction. The block handles one transaction at a time: it accepts the
// request while idle and then produces the results in order, waiting while
// rsp_stall holds the result register. Each result is set by a parallel key
// compare and oldest-slot select across all cells. The budget may only be
// written while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module byte_budget_lru_cache_core
   import bbl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [BUDGET_W-1:0]  csr_write_data,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_command,
   input  wire logic [KEY_W-1:0]     req_key,
   input  wire logic [LEN_W-1:0]     req_head_len,
   input  wire logic [LEN_W-1:0]     req_suffix_len,
   input  wire logic [WORD_W-1:0]    req_suffix_start,
   input  wire logic [WORD_W-1:0]    req_file_size,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic [KEY_W-1:0]          rsp_key_out,
   output logic [LEN_W-1:0]          rsp_head_len_out,
   output logic [LEN_W-1:0]          rsp_suffix_len_out,
   output logic [WORD_W-1:0]         rsp_suffix_start_out,
   output logic [WORD_W-1:0]         rsp_file_size_out,
   output logic                      rsp_last
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic state_ff, state_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [BUDGET_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // Latched request transaction.
   logic              cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [LEN_W-1:0]  hl_ff, sl_ff;
   logic [WORD_W-1:0] ss_ff, fs_ff;
   logic [SIZE_W-1:0] bytes_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [KEY_W-1:0]  rkey_ff, rkey_in;
   logic [LEN_W-1:0]  rhl_ff, rhl_in, rsl_ff, rsl_in;
   logic [WORD_W-1:0] rss_ff, rss_in, rfs_ff, rfs_in;
   logic              last_ff, last_in;

   cell_ctl_type  ctl;
   cell_stat_type stat [ENTRIES];
   logic [ENTRIES:0]   free_chain;
   logic [ENTRIES-1:0] valid_vec, match_vec;

   // Reductions over the cells; at most one cell raises each flag.
   logic              any_match;
   logic [IDX_W-1:0]  hit_idx, old_idx, free_idx, hit_rank;
   logic [KEY_W-1:0]  old_key;
   logic [SIZE_W-1:0] old_size;
   logic [LEN_W-1:0]  hit_hl, hit_sl;
   logic [WORD_W-1:0] hit_ss, hit_fs;

   logic out_free, emit, too_big, need_evict;
   logic [BUDGET_W:0] held_plus;

   assign free_chain[0] = 1'b0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      bbl_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctl             (ctl),
         .free_before_in  (free_chain[g]),
         .free_before_out (free_chain[g+1]),
         .stat            (stat[g])
      );
      assign valid_vec[g] = stat[g].valid;
      assign match_vec[g] = stat[g].match;
   end

   always_comb begin
      any_match = 1'b0;
      hit_idx   = '0;
      old_idx   = '0;
      free_idx  = '0;
      hit_rank  = '0;
      old_key   = '0;
      old_size  = '0;
      hit_hl    = '0;
      hit_sl    = '0;
      hit_ss    = '0;
      hit_fs    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (stat[i].match) begin
            any_match = 1'b1;
            hit_idx   = hit_idx | IDX_W'(i);
            hit_rank  = hit_rank | stat[i].rank;
            hit_hl    = hit_hl | stat[i].head_len;
            hit_sl    = hit_sl | stat[i].suffix_len;
            hit_ss    = hit_ss | stat[i].suffix_start;
            hit_fs    = hit_fs | stat[i].file_size;
         end
         if (stat[i].is_oldest) begin
            old_idx  = old_idx | IDX_W'(i);
            old_key  = old_key | stat[i].key;
            old_size = old_size | (SIZE_W'(stat[i].head_len) + SIZE_W'(stat[i].suffix_len));
         end
         if (stat[i].first_free) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = (state_ff == S_RUN) && out_free;
   assign too_big    = {{(BUDGET_W-SIZE_W){1'b0}}, bytes_ff} > budget_ff;
   assign held_plus  = {1'b0, held_ff} + (BUDGET_W+1)'(bytes_ff);
   assign need_evict = ((count_ff != '0) && (held_plus > {1'b0, budget_ff}))
                       || (count_ff == CNT_W'(ENTRIES));

   always_comb begin
      ctl.op           = OP_NONE;
      ctl.promote_rank = hit_rank;
      ctl.oldest_rank  = IDX_W'(count_ff - 1'b1);
      ctl.key          = key_ff;
      ctl.head_len     = hl_ff;
      ctl.suffix_len   = sl_ff;
      ctl.suffix_start = ss_ff;
      ctl.file_size    = fs_ff;

      state_in     = state_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      st_in        = st_ff;
      slot_in      = slot_ff;
      rkey_in      = rkey_ff;
      rhl_in       = rhl_ff;
      rsl_in       = rsl_ff;
      rss_in       = rss_ff;
      rfs_in       = rfs_ff;
      last_in      = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               slot_in      = '0;
               rkey_in      = key_ff;
               rhl_in       = '0;
               rsl_in       = '0;
               rss_in       = '0;
               rfs_in       = '0;
               last_in      = 1'b1;
               state_in     = S_IDLE;
               if (!cmd_ff) begin
                  if (any_match) begin
                     ctl.op  = OP_PROMOTE;
                     st_in   = ST_HIT;
                     slot_in = SLOT_W'(hit_idx);
                     rhl_in  = hit_hl;
                     rsl_in  = hit_sl;
                     rss_in  = hit_ss;
                     rfs_in  = hit_fs;
                  end else begin
                     st_in = ST_MISS;
                  end
               end else if (too_big) begin
                  st_in = ST_TOO_BIG;
               end else if (any_match) begin
                  st_in = ST_PRESENT;
               end else if (need_evict) begin
                  // Evict the oldest entry and stay for the next result.
                  ctl.op   = OP_EVICT;
                  st_in    = ST_EVICTED;
                  slot_in  = SLOT_W'(old_idx);
                  rkey_in  = old_key;
                  last_in  = 1'b0;
                  state_in = S_RUN;
                  held_in  = (held_ff >= BUDGET_W'(old_size))
                             ? held_ff - BUDGET_W'(old_size) : '0;
                  count_in = count_ff - 1'b1;
               end else begin
                  ctl.op   = OP_STORE;
                  st_in    = ST_STORED;
                  slot_in  = SLOT_W'(free_idx);
                  held_in  = BUDGET_W'(held_plus);
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign budget_in = csr_write_enable ? csr_write_data : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         budget_ff    <= BUDGET_RESET;
         held_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         budget_ff    <= budget_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         hl_ff    <= req_head_len;
         sl_ff    <= req_suffix_len;
         ss_ff    <= req_suffix_start;
         fs_ff    <= req_file_size;
         bytes_ff <= SIZE_W'(req_head_len) + SIZE_W'(req_suffix_len);
      end
      st_ff   <= st_in;
      slot_ff <= slot_in;
      rkey_ff <= rkey_in;
      rhl_ff  <= rhl_in;
      rsl_ff  <= rsl_in;
      rss_ff  <= rss_in;
      rfs_ff  <= rfs_in;
      last_ff <= last_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = st_ff;
   assign rsp_slot             = slot_ff;
   assign rsp_key_out          = rkey_ff;
   assign rsp_head_len_out     = rhl_ff;
   assign rsp_suffix_len_out   = rsl_ff;
   assign rsp_suffix_start_out = rss_ff;
   assign rsp_file_size_out    = rfs_ff;
   assign rsp_last             = last_ff;

   // The occupancy count must track the valid slots exactly.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_vec)))
      else $error("slot count disagrees with valid slots");

   // The current key matches at most one valid slot.
   a_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key matched in more than one slot");

   // The free-slot chain reports a free slot exactly when the table is not full.
   a_free: assert property (@(posedge clock) disable iff (reset)
      free_chain[ENTRIES] == (count_ff != CNT_W'(ENTRIES)))
      else $error("free-slot chain disagrees with slot count");

   // The final result of a transaction returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && last_in) |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_last))
      else $error("final result did not end the transaction");

endmodule
`default_nettype wire

[src/bbl_cell.sv]
// One slot of the cache: entry storage, recency rank and free-slot chain link.
`timescale 1ns / 1ps
`default_nettype none
module bbl_cell
   import bbl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctl_type  ctl,
   input  wire logic          free_before_in,
   output logic               free_before_out,
   output cell_stat_type      stat
);

   logic              valid_ff, valid_in;
   logic [IDX_W-1:0]  rank_ff, rank_in;
   logic [KEY_W-1:0]  key_ff;
   logic [LEN_W-1:0]  head_len_ff, suffix_len_ff;
   logic [WORD_W-1:0] suffix_start_ff, file_size_ff;
   logic              match, is_oldest, first_free;

   assign match           = valid_ff && (key_ff == ctl.key);
   assign is_oldest       = valid_ff && (rank_ff == ctl.oldest_rank);
   assign first_free      = !valid_ff && !free_before_in;
   assign free_before_out = free_before_in || !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      case (ctl.op)
         OP_PROMOTE: begin
            if (match) begin
               rank_in = '0;
            end else if (valid_ff && rank_ff < ctl.promote_rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         OP_EVICT: begin
            if (is_oldest) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end
         end
         OP_STORE: begin
            if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end else if (first_free) begin
               valid_in = 1'b1;
               rank_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_STORE && first_free) begin
         key_ff          <= ctl.key;
         head_len_ff     <= ctl.head_len;
         suffix_len_ff   <= ctl.suffix_len;
         suffix_start_ff <= ctl.suffix_start;
         file_size_ff    <= ctl.file_size;
      end
   end

   always_comb begin
      stat.valid        = valid_ff;
      stat.match        = match;
      stat.is_oldest    = is_oldest;
      stat.first_free   = first_free;
      stat.rank         = rank_ff;
      stat.key          = key_ff;
      stat.head_len     = head_len_ff;
      stat.suffix_len   = suffix_len_ff;
      stat.suffix_start = suffix_start_ff;
      stat.file_size    = file_size_ff;
   end

endmodule
`default_nettype wire
